[rtl/sspm_pkg.sv]
package sspm_pkg;

	// command codes of an input beat
	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_GLYPH  = 2'd1,
		CMD_POINT  = 2'd2,
		CMD_BRIGHT = 2'd3
	} cmd_t;

	// configuration register indexes
	localparam logic [2:0] REG_ANTI_GHOST    = 3'd0;
	localparam logic [2:0] REG_BRIGHT_TOP    = 3'd1;
	localparam logic [2:0] REG_MIRROR_START  = 3'd2;
	localparam logic [2:0] REG_SEG_DIRECT    = 3'd3;
	localparam logic [2:0] REG_DIG_LOW       = 3'd4;

	localparam int          GLYPH_COUNT = 12;
	localparam int          POINT_BIT   = 7;

	typedef struct packed {
		logic [15:0] anti_ghost_limit;
		logic [15:0] brightness_top;
		logic [2:0]  mirrored_digit_start;
		logic        segment_drive_direct;
		logic        digit_enable_low;
	} cfg_t;

	// logical levels after one beat, before pin polarity
	typedef struct packed {
		logic [7:0] seg_level;
		logic [3:0] dig_level;
		logic       rejected;
	} res_t;

	// segments a..g for a glyph code; upper half is the mirrored set
	function automatic logic [6:0] glyph_lookup(input logic mirror, input logic [3:0] code);
		logic [6:0] g;
		g = 7'h00;
		if (!mirror) begin
			unique case (code)
				4'd0: g = 7'h3F;
				4'd1: g = 7'h06;
				4'd2: g = 7'h5B;
				4'd3: g = 7'h4F;
				4'd4: g = 7'h66;
				4'd5: g = 7'h6D;
				4'd6: g = 7'h7D;
				4'd7: g = 7'h07;
				4'd8: g = 7'h7F;
				4'd9: g = 7'h6F;
				default: g = 7'h00;
			endcase
		end else begin
			unique case (code)
				4'd0: g = 7'h3F;
				4'd1: g = 7'h30;
				4'd2: g = 7'h5B;
				4'd3: g = 7'h79;
				4'd4: g = 7'h74;
				4'd5: g = 7'h6D;
				4'd6: g = 7'h6F;
				4'd7: g = 7'h38;
				4'd8: g = 7'h7F;
				4'd9: g = 7'h7D;
				default: g = 7'h00;
			endcase
		end
		return g;
	endfunction

endpackage

[rtl/seven_segment_pwm_multiplexer.sv]
// channel   signals                                       beat
// input     in_valid/in_ready, command, digit_select,     one command
//           operand_value
// output    out_valid/out_ready, segment_pins,            pin levels after that command
//           digit_pins, command_rejected
// config    cfg_we, cfg_index, cfg_data                   one register write, no stall
//
// each beat passes the input register, then the scan/buffer update into the output register
// one beat per cycle sustained while out_ready is high; set by the single state update in the core
// the output register holds while out_ready is low; the input register still takes one beat
// arst_n clears the scan position, levels, digit buffers and config to their defaults
module seven_segment_pwm_multiplexer
	import sspm_pkg::*;
#(
	parameter int DIGIT_COUNT = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         command,
	input  logic [2:0]         digit_select,
	input  logic signed [15:0] operand_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         segment_pins,
	output logic [3:0]         digit_pins,
	output logic               command_rejected,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	cfg_t               cfg_q;
	logic               valid_s1;
	cmd_t               command_s1;
	logic [2:0]         digit_s1;
	logic signed [15:0] operand_s1;
	logic               out_valid_q;
	logic [7:0]         segment_pins_q;
	logic [3:0]         digit_pins_q;
	logic               rejected_q;
	logic               advance;
	logic               fire;
	res_t               res;

	// output register free, or being emptied this cycle
	assign advance  = !out_valid_q || out_ready;
	assign fire     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.anti_ghost_limit     <= 16'd2;
			cfg_q.brightness_top       <= 16'd100;
			cfg_q.mirrored_digit_start <= 3'd2;
			cfg_q.segment_drive_direct <= 1'b1;
			cfg_q.digit_enable_low     <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ANTI_GHOST:   cfg_q.anti_ghost_limit     <= cfg_data;
				REG_BRIGHT_TOP:   cfg_q.brightness_top       <= cfg_data;
				REG_MIRROR_START: cfg_q.mirrored_digit_start <= cfg_data[2:0];
				REG_SEG_DIRECT:   cfg_q.segment_drive_direct <= cfg_data[0];
				REG_DIG_LOW:      cfg_q.digit_enable_low     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			command_s1 <= cmd_t'(command);
			digit_s1   <= digit_select;
			operand_s1 <= operand_value;
		end
	end

	sspm_core #(
		.DIGIT_COUNT(DIGIT_COUNT)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (fire),
		.cmd   (command_s1),
		.dig   (digit_s1),
		.val   (operand_s1),
		.cfg   (cfg_q),
		.res   (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// pin polarity applied on the way out
	always_ff @(posedge clk) begin
		if (fire) begin
			segment_pins_q <= cfg_q.segment_drive_direct ? res.seg_level : ~res.seg_level;
			digit_pins_q   <= cfg_q.digit_enable_low ? ~res.dig_level : res.dig_level;
			rejected_q     <= res.rejected;
		end
	end

	assign out_valid        = out_valid_q;
	assign segment_pins     = segment_pins_q;
	assign digit_pins       = digit_pins_q;
	assign command_rejected = rejected_q;

endmodule

[rtl/sspm_core.sv]
module sspm_core
	import sspm_pkg::*;
#(
	parameter int DIGIT_COUNT = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  cmd_t               cmd,
	input  logic [2:0]         dig,
	input  logic signed [15:0] val,
	input  cfg_t               cfg,
	output res_t               res
);

	localparam int CDW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

	logic [CDW-1:0] cur_q;
	logic [15:0]    slot_q;
	logic [15:0]    bright_q [DIGIT_COUNT];
	logic [6:0]     glyph_q  [DIGIT_COUNT];
	logic           point_q  [DIGIT_COUNT];
	logic [7:0]     seg_level_q;
	logic [3:0]     dig_level_q;

	logic           valid_digit;
	logic [CDW-1:0] dig_idx;
	logic           glyph_ok;
	logic           mirror;
	logic [6:0]     new_glyph;
	logic [14:0]    lvl;
	logic [16:0]    thr;
	logic [15:0]    cap;
	logic [15:0]    new_bright;
	logic [16:0]    slot_next;
	logic           period_end;
	logic [CDW-1:0] cur_next;
	logic [3:0]     cur_onehot;
	logic           wr_glyph, wr_point, wr_bright;

	assign valid_digit = 32'(dig) < DIGIT_COUNT;
	assign dig_idx     = CDW'(dig);
	assign glyph_ok    = (val >= 16'sd0) && (val < 16'(GLYPH_COUNT));
	assign mirror      = dig >= cfg.mirrored_digit_start;
	assign new_glyph   = glyph_lookup(mirror, val[3:0]);

	// brightness threshold with saturation below the period top
	assign lvl        = val[15] ? 15'd0 : val[14:0];
	assign thr        = 17'(cfg.anti_ghost_limit) + 17'd1 + 17'(lvl);
	assign cap        = (cfg.brightness_top >= 16'd2) ? cfg.brightness_top - 16'd2 : 16'd0;
	assign new_bright = (thr >= 17'(cap)) ? cap : thr[15:0];

	assign wr_glyph  = fire && (cmd == CMD_GLYPH) && valid_digit && glyph_ok;
	assign wr_point  = fire && (cmd == CMD_POINT) && valid_digit
	                   && ((val == 16'sd0) || (val == 16'sd1));
	assign wr_bright = fire && (cmd == CMD_BRIGHT) && valid_digit;

	assign slot_next  = 17'(slot_q) + 17'd1;
	assign period_end = (slot_next >= 17'(cfg.brightness_top)) || slot_next[16];
	assign cur_next   = (32'(cur_q) >= DIGIT_COUNT - 1) ? '0 : cur_q + CDW'(1);

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			cur_onehot[i] = (32'(cur_q) == i);
		end
	end

	// next logical levels and reject flag
	always_comb begin
		res.seg_level = seg_level_q;
		res.dig_level = dig_level_q;
		res.rejected  = 1'b0;
		if (cmd == CMD_TICK) begin
			if (slot_q <= 16'd1) begin
				res.seg_level = '0;
				res.dig_level = '0;
			end else if (slot_q <= cfg.anti_ghost_limit) begin
				res.seg_level = {point_q[cur_q], glyph_q[cur_q]};
				res.dig_level = cur_onehot;
			end else if (slot_q >= bright_q[cur_q]) begin
				res.seg_level = '0;
				res.dig_level = '0;
			end
		end else if (!valid_digit) begin
			res.rejected = 1'b1;
		end else if (cmd == CMD_GLYPH) begin
			res.rejected = !glyph_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= '0;
			slot_q      <= '0;
			seg_level_q <= '0;
			dig_level_q <= '0;
		end else if (fire && (cmd == CMD_TICK)) begin
			seg_level_q <= res.seg_level;
			dig_level_q <= res.dig_level;
			if (period_end) begin
				cur_q  <= cur_next;
				slot_q <= '0;
			end else begin
				slot_q <= slot_next[15:0];
			end
		end
	end

	// per-digit buffers, reset to blank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIGIT_COUNT; i++) begin
				bright_q[i] <= '0;
				glyph_q[i]  <= '0;
				point_q[i]  <= 1'b0;
			end
		end else begin
			for (int i = 0; i < DIGIT_COUNT; i++) begin
				if (32'(dig_idx) == i) begin
					if (wr_glyph) begin
						glyph_q[i] <= new_glyph;
					end
					if (wr_point) begin
						point_q[i] <= val[0];
					end
					if (wr_bright) begin
						bright_q[i] <= new_bright;
					end
				end
			end
		end
	end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
	import sspm_pkg::*;

	localparam int DIGITS         = 4;
	localparam int CYCLE_LIMIT    = 100000;
	localparam int LONG_HOLD_AT   = 200;	// beat count at which the sink backs off for a while
	localparam int LONG_HOLD_LEN  = 60;
	localparam int LATENCY_PAUSE  = 6;

	// segment patterns a..g: entries 0..11 plain set, 12..23 mirrored set
	localparam logic [0:23][6:0] FACES = {
		7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F, 7'h00, 7'h00,
		7'h3F, 7'h30, 7'h5B, 7'h79, 7'h74, 7'h6D, 7'h6F, 7'h38, 7'h7F, 7'h7D, 7'h00, 7'h00
	};

	typedef struct packed {
		cmd_t               op;
		logic [2:0]         sel;
		logic signed [15:0] arg;
	} cmd_beat_t;

	typedef struct packed {
		logic [7:0] seg;
		logic [3:0] dig;
		logic       rej;
	} pin_beat_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         command = CMD_TICK;
	logic [2:0]         digit_select = 3'd0;
	logic signed [15:0] operand_value = 16'sd0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [7:0]         segment_pins;
	logic [3:0]         digit_pins;
	logic               command_rejected;
	logic               cfg_we = 1'b0;
	logic [2:0]         cfg_index = REG_ANTI_GHOST;
	logic [15:0]        cfg_data = 16'd0;

	seven_segment_pwm_multiplexer #(.DIGIT_COUNT(DIGITS)) u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.command          (command),
		.digit_select     (digit_select),
		.operand_value    (operand_value),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.segment_pins     (segment_pins),
		.digit_pins       (digit_pins),
		.command_rejected (command_rejected),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	always #6 clk = ~clk;

	// display state as the testbench expects it
	cfg_t       cfg;
	logic [1:0] scan_digit;
	logic [15:0] slot_ctr;
	logic [15:0] bright_thr [DIGITS];
	logic [7:0] digit_pattern [DIGITS];
	logic [7:0] lit_segments;
	logic [3:0] lit_digits;

	cmd_beat_t pending_cmds [$];
	pin_beat_t expected_pins [$];
	cmd_beat_t launch_cmd;

	int  issued_total = 0;
	int  accepted_total = 0;
	int  tick_beats = 0;
	int  rejected_writes = 0;
	int  beats_checked = 0;
	int  mismatches = 0;
	int  cycle_count = 0;
	int  phase_count = 0;
	int  send_gap = 0;
	int  stall_left = 0;
	int  hold_left = 0;
	bit  quiet_run = 1'b0;

	// advance the display state by one command and form the pin levels it leaves
	function automatic pin_beat_t apply_command(input cmd_t op, input logic [2:0] sel,
			input logic signed [15:0] arg);
		pin_beat_t   r;
		logic [16:0] nxt_slot;
		int          lvl;
		int          thr;
		int          cap;
		int          face_idx;
		r.rej = 1'b0;
		if (op == CMD_TICK) begin
			// first two slots blank, then drive up to the anti-ghost limit,
			// then blank once the digit's threshold is reached
			if (slot_ctr <= 16'd1) begin
				lit_segments = 8'h00;
				lit_digits   = 4'h0;
			end else if (slot_ctr <= cfg.anti_ghost_limit) begin
				lit_segments = digit_pattern[scan_digit];
				lit_digits   = 4'b0001 << scan_digit;
			end else if (slot_ctr >= bright_thr[scan_digit]) begin
				lit_segments = 8'h00;
				lit_digits   = 4'h0;
			end
			// 17-bit compare so a full counter always ends the digit period
			nxt_slot = {1'b0, slot_ctr} + 17'd1;
			if (nxt_slot >= {1'b0, cfg.brightness_top} || nxt_slot > 17'h0FFFF) begin
				scan_digit = scan_digit + 2'd1;
				slot_ctr   = 16'd0;
			end else begin
				slot_ctr = nxt_slot[15:0];
			end
		end else if (sel >= DIGITS) begin
			r.rej = 1'b1;	// digit without a position
		end else begin
			case (op)
				CMD_GLYPH: begin
					if (arg < 0 || arg >= GLYPH_COUNT) begin
						r.rej = 1'b1;
					end else begin
						face_idx = int'(arg) + ((sel >= cfg.mirrored_digit_start) ? GLYPH_COUNT : 0);
						// the point survives a glyph change
						digit_pattern[sel[1:0]] = {digit_pattern[sel[1:0]][POINT_BIT], FACES[face_idx]};
					end
				end
				CMD_POINT: begin
					// flags other than 0 and 1 leave the point alone without rejecting
					if (arg == 0)
						digit_pattern[sel[1:0]][POINT_BIT] = 1'b0;
					else if (arg == 1)
						digit_pattern[sel[1:0]][POINT_BIT] = 1'b1;
				end
				default: begin
					lvl = (arg < 0) ? 0 : int'(arg);
					thr = int'(cfg.anti_ghost_limit) + 1 + lvl;
					cap = (cfg.brightness_top >= 16'd2) ? int'(cfg.brightness_top) - 2 : 0;
					if (thr >= cap)
						thr = cap;
					bright_thr[sel[1:0]] = thr[15:0];
				end
			endcase
		end
		r.seg = cfg.segment_drive_direct ? lit_segments : ~lit_segments;
		r.dig = cfg.digit_enable_low ? ~lit_digits : lit_digits;
		return r;
	endfunction

	function automatic cmd_beat_t random_cmd();
		cmd_beat_t b;
		int        pick;
		pick = $urandom_range(0, 99);
		// ticks dominate so the scan runs deep through every digit period
		if (pick < 55)
			b.op = CMD_TICK;
		else if (pick < 72)
			b.op = CMD_GLYPH;
		else if (pick < 84)
			b.op = CMD_POINT;
		else
			b.op = CMD_BRIGHT;
		b.sel = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, 3)) : 3'($urandom_range(4, 7));
		case (b.op)
			CMD_GLYPH:  b.arg = ($urandom_range(0, 99) < 80) ? 16'($urandom_range(0, 11)) : 16'($urandom);
			CMD_POINT:  b.arg = ($urandom_range(0, 99) < 80) ? 16'($urandom_range(0, 1)) : 16'($urandom);
			CMD_BRIGHT: b.arg = ($urandom_range(0, 99) < 55) ? 16'($urandom_range(0, 40)) : 16'($urandom);
			default:    b.arg = 16'($urandom);
		endcase
		return b;
	endfunction

	task automatic push_cmd(input cmd_t op, input logic [2:0] sel, input logic signed [15:0] arg);
		cmd_beat_t b;
		b.op  = op;
		b.sel = sel;
		b.arg = arg;
		pending_cmds.push_back(b);
		issued_total++;
	endtask

	// block is idle once every issued beat went in and every result came back
	task automatic wait_drained();
		while (accepted_total != issued_total || expected_pins.size() != 0)
			@(posedge clk);
		repeat (LATENCY_PAUSE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
	endtask

	task automatic run_phase(input cfg_t c, input int n_random);
		write_reg(REG_ANTI_GHOST, c.anti_ghost_limit);
		write_reg(REG_BRIGHT_TOP, c.brightness_top);
		write_reg(REG_MIRROR_START, 16'(c.mirrored_digit_start));
		write_reg(REG_SEG_DIRECT, 16'(c.segment_drive_direct));
		write_reg(REG_DIG_LOW, 16'(c.digit_enable_low));
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg = c;
		phase_count++;
		repeat (n_random) begin
			pending_cmds.push_back(random_cmd());
			issued_total++;
		end
		wait_drained();
	endtask

	// source side: pops pending beats, holds each until taken, predicts on acceptance
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				expected_pins.push_back(apply_command(cmd_t'(command), digit_select, operand_value));
				if (command == CMD_TICK)
					tick_beats++;
				else if (expected_pins[$].rej)
					rejected_writes++;
				accepted_total++;
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_cmds.size() > 0) begin
					launch_cmd    = pending_cmds.pop_front();
					command       <= launch_cmd.op;
					digit_select  <= launch_cmd.sel;
					operand_value <= launch_cmd.arg;
					in_valid      <= 1'b1;
					// idle burst after this beat goes in
					if (!quiet_run && $urandom_range(0, 99) < 15)
						send_gap = $urandom_range(1, 3);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// sink side: checks each result beat against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_pins.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: seg %02h dig %01h rej %0b",
						segment_pins, digit_pins, command_rejected);
			end else begin
				if (segment_pins !== expected_pins[0].seg || digit_pins !== expected_pins[0].dig ||
						command_rejected !== expected_pins[0].rej) begin
					mismatches++;
					if (mismatches <= 10)
						$display("beat %0d mismatch: seg %02h/%02h dig %01h/%01h rej %0b/%0b (exp/act)",
							beats_checked, expected_pins[0].seg, segment_pins,
							expected_pins[0].dig, digit_pins, expected_pins[0].rej, command_rejected);
				end
				void'(expected_pins.pop_front());
			end
			beats_checked++;
			// one long back-off so the input register fills and in_ready drops
			if (beats_checked == LONG_HOLD_AT)
				hold_left = LONG_HOLD_LEN;
		end
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (!quiet_run && $urandom_range(0, 99) < 15) begin
			stall_left = $urandom_range(0, 2);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				expected_pins.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		// reset values of the registers and the display state
		cfg = '{16'd2, 16'd100, 3'd2, 1'b1, 1'b1};
		scan_digit   = 2'd0;
		slot_ctr     = 16'd0;
		lit_segments = 8'h00;
		lit_digits   = 4'h0;
		for (int i = 0; i < DIGITS; i++) begin
			bright_thr[i]    = 16'd0;
			digit_pattern[i] = 8'h00;
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part under the reset configuration
		push_cmd(CMD_GLYPH, 3'd0, 16'sd0);
		push_cmd(CMD_GLYPH, 3'd1, 16'sd11);
		push_cmd(CMD_GLYPH, 3'd2, 16'sd1);	// mirrored half from digit 2
		push_cmd(CMD_GLYPH, 3'd3, 16'sd9);
		push_cmd(CMD_GLYPH, 3'd0, -16'sd1);	// illegal glyphs
		push_cmd(CMD_GLYPH, 3'd1, 16'sd12);
		push_cmd(CMD_GLYPH, 3'd2, -16'sd32768);
		push_cmd(CMD_GLYPH, 3'd3, 16'sd32767);
		push_cmd(CMD_GLYPH, 3'd7, 16'sd3);	// digits beyond the display
		push_cmd(CMD_POINT, 3'd4, 16'sd1);
		push_cmd(CMD_BRIGHT, 3'd5, 16'sd10);
		push_cmd(CMD_POINT, 3'd0, 16'sd1);
		push_cmd(CMD_POINT, 3'd2, 16'sd1);
		push_cmd(CMD_POINT, 3'd1, 16'sd2);	// odd point flags change nothing
		push_cmd(CMD_POINT, 3'd3, -16'sd1);
		push_cmd(CMD_GLYPH, 3'd0, 16'sd8);	// point kept across glyph change
		push_cmd(CMD_BRIGHT, 3'd0, -16'sd5);	// negative level counts as zero
		push_cmd(CMD_BRIGHT, 3'd1, 16'sd32767);	// saturates at top minus two
		push_cmd(CMD_BRIGHT, 3'd2, 16'sd0);
		push_cmd(CMD_BRIGHT, 3'd3, 16'sd40);
		repeat (6) push_cmd(CMD_TICK, 3'($urandom_range(0, 7)), 16'($urandom));
		repeat (100) begin
			pending_cmds.push_back(random_cmd());
			issued_total++;
		end
		wait_drained();
		phase_count++;

		// register settings: anti-ghost limit, top, mirror start, polarities
		run_phase('{16'd5,     16'd12,    3'd0, 1'b0, 1'b0}, 140);
		run_phase('{16'd0,     16'd3,     3'd4, 1'b1, 1'b0}, 120);
		run_phase('{16'd65535, 16'd20,    3'd1, 1'b0, 1'b1}, 120);
		run_phase('{16'd3,     16'd65535, 3'd3, 1'b1, 1'b1}, 80);
		quiet_run = 1'b1;	// closing stretch at full rate on both sides
		run_phase('{16'd2,     16'd16,    3'd2, 1'b1, 1'b1}, 170);

		mismatches += expected_pins.size();
		$display("covered %0d command beats over %0d register settings: %0d ticks, %0d rejected writes",
			accepted_total, phase_count, tick_beats, rejected_writes);
		$display("checked %0d result beats, %0d mismatches", beats_checked, mismatches);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
